### rtl/core/bcle_pkg.sv
// bcle_pkg: shared types and codes for the bounded byte list engine
// holds sequencer states, request function codes and status codes
// no dependencies
`default_nettype none

package bcle_pkg;

    typedef enum logic [3:0] {
        FN_PUSH_BACK  = 4'd0,
        FN_PUSH_FRONT = 4'd1,
        FN_INSERT_AT  = 4'd2,
        FN_INSERT_ORD = 4'd3,
        FN_POP_FRONT  = 4'd4,
        FN_POP_BACK   = 4'd5,
        FN_REMOVE     = 4'd6,
        FN_REPLACE    = 4'd7,
        FN_READ       = 4'd8,
        FN_CLEAR      = 4'd9
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SEARCH,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_WRITE,
        S_READ,
        S_READ_CAP,
        S_SUM0,
        S_SUM1,
        S_SUM2
    } state_t;

endpackage

`default_nettype wire

### rtl/core/bounded_char_list_engine_core.sv
// bounded_char_list_engine_core: ordered byte list with insert, remove, replace, lookup and clear requests
// one shared single-port-write / single-port-read entry memory under a small sequencer
// depends on bcle_pkg
//
//   channel   handshake       payload
//   request   start / busy    func, ch, position
//   result    done (strobe)   status, read_byte, count, first_byte, last_byte
//
// every request passes S_DECIDE and ends with S_SUM0, S_SUM1 and S_SUM2, after which done is
// registered high; an accepted append or replace adds S_WRITE, a read adds S_READ and S_READ_CAP,
// an insert that moves entries adds S_SHIFT_UP, which moves them up one by one, and S_WRITE,
// a removal adds S_SHIFT_DN, which moves the later entries down one by one; an ordered insert
// first runs S_SEARCH, which compares the entries in order until it finds the place
// reset clears the count and the sequencer; entry contents are not cleared
// busy is high from accept until done; done lasts one cycle and cannot be stalled
`default_nettype none

module bounded_char_list_engine_core #(
    parameter int DEPTH = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [3:0] func,
    input  wire logic [7:0] ch,
    input  wire logic [5:0] position,
    output logic            done,
    output logic [1:0]      status,
    output logic [7:0]      read_byte,
    output logic [6:0]      count,
    output logic [7:0]      first_byte,
    output logic [7:0]      last_byte
);

    import bcle_pkg::*;

    localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = (CW > 6) ? CW : 6;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            cv_reg, cv_next;
    logic            wpend_reg, wpend_next;
    logic            done_reg, done_next;

    logic [3:0]      func_reg, func_next;
    logic [7:0]      ch_reg, ch_next;
    logic [5:0]      pos_reg, pos_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic [AW-1:0]   waddr_reg, waddr_next;
    logic [AW-1:0]   tgt_reg, tgt_next;
    logic [1:0]      st_reg, st_next;
    logic [7:0]      rdb_reg, rdb_next;
    logic [7:0]      first_reg, first_next;

    logic [1:0]      res_status_reg, res_status_next;
    logic [7:0]      res_read_reg, res_read_next;
    logic [6:0]      res_count_reg, res_count_next;
    logic [7:0]      res_first_reg, res_first_next;
    logic [7:0]      res_last_reg, res_last_next;

    logic [7:0]      entries_reg [DEPTH];
    logic [7:0]      rdata_reg;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            we;
    logic [AW-1:0]   wr_addr;
    logic [7:0]      wr_data;

    // next state and datapath
    always_comb
    begin
        logic          do_place;
        logic [CW-1:0] t_place;
        logic          do_take;
        logic [CW-1:0] t_take;
        logic [WW-1:0] pos_w;
        logic [WW-1:0] cnt_w;
        logic          full;

        do_place = 1'b0;
        t_place  = '0;
        do_take  = 1'b0;
        t_take   = '0;
        pos_w    = WW'(pos_reg);
        cnt_w    = WW'(count_reg);
        full     = (count_reg == CW'(DEPTH));

        state_next      = state_reg;
        count_next      = count_reg;
        rem_next        = rem_reg;
        idx_next        = idx_reg;
        cv_next         = cv_reg;
        wpend_next      = wpend_reg;
        done_next       = 1'b0;
        func_next       = func_reg;
        ch_next         = ch_reg;
        pos_next        = pos_reg;
        ptr_next        = ptr_reg;
        waddr_next      = waddr_reg;
        tgt_next        = tgt_reg;
        st_next         = st_reg;
        rdb_next        = rdb_reg;
        first_next      = first_reg;
        res_status_next = res_status_reg;
        res_read_next   = res_read_reg;
        res_count_next  = res_count_reg;
        res_first_next  = res_first_reg;
        res_last_next   = res_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next  = func;
                    ch_next    = ch;
                    pos_next   = position;
                    rdb_next   = 8'd0;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                st_next    = ST_OK;
                wpend_next = 1'b0;
                state_next = S_SUM0;
                case (func_reg)
                    FN_PUSH_BACK:
                    begin
                        do_place = 1'b1;
                        t_place  = count_reg;
                    end
                    FN_PUSH_FRONT:
                    begin
                        do_place = 1'b1;
                        t_place  = '0;
                    end
                    FN_INSERT_AT:
                    begin
                        if (pos_w > cnt_w)
                        begin
                            st_next = ST_RANGE;
                        end
                        else
                        begin
                            do_place = 1'b1;
                            t_place  = CW'(pos_w);
                        end
                    end
                    FN_INSERT_ORD:
                    begin
                        if (full)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            idx_next   = '0;
                            cv_next    = 1'b0;
                            state_next = S_SEARCH;
                        end
                    end
                    FN_POP_FRONT:
                    begin
                        do_take = 1'b1;
                        t_take  = '0;
                    end
                    FN_POP_BACK:
                    begin
                        do_take = 1'b1;
                        t_take  = count_reg - CW'(1);
                    end
                    FN_REMOVE:
                    begin
                        if (count_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else if (pos_w >= cnt_w)
                        begin
                            st_next = ST_RANGE;
                        end
                        else
                        begin
                            do_take = 1'b1;
                            t_take  = CW'(pos_w);
                        end
                    end
                    FN_REPLACE, FN_READ:
                    begin
                        if (count_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                        end
                        else if (pos_w >= cnt_w)
                        begin
                            st_next = ST_RANGE;
                        end
                        else
                        begin
                            tgt_next   = AW'(pos_w);
                            state_next = (func_reg == FN_READ) ? S_READ : S_WRITE;
                        end
                    end
                    FN_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        st_next = ST_OK;
                    end
                endcase
            end
            S_SEARCH:
            begin
                if (cv_reg && (rdata_reg >= ch_reg))
                begin
                    do_place = 1'b1;
                    t_place  = idx_reg - CW'(1);
                end
                else if (idx_reg == count_reg)
                begin
                    do_place = 1'b1;
                    t_place  = count_reg;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    cv_next  = 1'b1;
                end
            end
            S_SHIFT_UP:
            begin
                if (rem_reg != '0)
                begin
                    ptr_next   = ptr_reg - AW'(1);
                    waddr_next = ptr_reg + AW'(1);
                    rem_next   = rem_reg - CW'(1);
                    wpend_next = 1'b1;
                end
                else
                begin
                    wpend_next = 1'b0;
                    state_next = S_WRITE;
                end
            end
            S_SHIFT_DN:
            begin
                if (rem_reg != '0)
                begin
                    ptr_next   = ptr_reg + AW'(1);
                    waddr_next = ptr_reg - AW'(1);
                    rem_next   = rem_reg - CW'(1);
                    wpend_next = 1'b1;
                end
                else
                begin
                    wpend_next = 1'b0;
                    state_next = S_SUM0;
                end
            end
            S_WRITE:
            begin
                state_next = S_SUM0;
            end
            S_READ:
            begin
                state_next = S_READ_CAP;
            end
            S_READ_CAP:
            begin
                rdb_next   = rdata_reg;
                state_next = S_SUM0;
            end
            S_SUM0:
            begin
                state_next = S_SUM1;
            end
            S_SUM1:
            begin
                first_next = rdata_reg;
                state_next = S_SUM2;
            end
            S_SUM2:
            begin
                res_status_next = st_reg;
                res_read_next   = rdb_reg;
                res_count_next  = 7'(count_reg);
                res_first_next  = (count_reg != '0) ? first_reg : 8'd0;
                res_last_next   = (count_reg != '0) ? rdata_reg : 8'd0;
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // insert at a checked position not above the count, or reject with ST_FULL when full
        if (do_place)
        begin
            if (full)
            begin
                st_next    = ST_FULL;
                state_next = S_SUM0;
            end
            else
            begin
                count_next = count_reg + CW'(1);
                tgt_next   = AW'(t_place);
                if (t_place < count_reg)
                begin
                    rem_next   = count_reg - t_place;
                    ptr_next   = AW'(count_reg - CW'(1));
                    wpend_next = 1'b0;
                    state_next = S_SHIFT_UP;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
        end

        // removal at a position checked against the count, or reject with ST_EMPTY when empty
        if (do_take)
        begin
            if (count_reg == '0)
            begin
                st_next    = ST_EMPTY;
                state_next = S_SUM0;
            end
            else
            begin
                count_next = count_reg - CW'(1);
                rem_next   = count_reg - CW'(1) - t_take;
                ptr_next   = AW'(t_take + CW'(1));
                wpend_next = 1'b0;
                state_next = S_SHIFT_DN;
            end
        end
    end

    // memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        we      = 1'b0;
        wr_addr = waddr_reg;
        wr_data = rdata_reg;
        case (state_reg)
            S_SEARCH:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(idx_reg);
            end
            S_SHIFT_UP, S_SHIFT_DN:
            begin
                we      = wpend_reg;
                rd_en   = (rem_reg != '0);
                rd_addr = ptr_reg;
            end
            S_WRITE:
            begin
                we      = 1'b1;
                wr_addr = tgt_reg;
                wr_data = ch_reg;
            end
            S_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = tgt_reg;
            end
            S_SUM0:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            S_SUM1:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(count_reg - CW'(1));
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entries_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= entries_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rem_reg   <= '0;
            idx_reg   <= '0;
            cv_reg    <= 1'b0;
            wpend_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            idx_reg   <= idx_next;
            cv_reg    <= cv_next;
            wpend_reg <= wpend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        ch_reg         <= ch_next;
        pos_reg        <= pos_next;
        ptr_reg        <= ptr_next;
        waddr_reg      <= waddr_next;
        tgt_reg        <= tgt_next;
        st_reg         <= st_next;
        rdb_reg        <= rdb_next;
        first_reg      <= first_next;
        res_status_reg <= res_status_next;
        res_read_reg   <= res_read_next;
        res_count_reg  <= res_count_next;
        res_first_reg  <= res_first_next;
        res_last_reg   <= res_last_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = res_status_reg;
    assign read_byte  = res_read_reg;
    assign count      = res_count_reg;
    assign first_byte = res_first_reg;
    assign last_byte  = res_last_reg;

endmodule

`default_nettype wire
